/* design/sbrpd_pkg.sv */
// Shared types, widths and constants for the per-bin random pitch drift block.
// Used by every module in the design folder; depends on nothing else.
`timescale 1ns / 1ps

package sbrpd_pkg;

  localparam int NUM_BINS_DEFAULT = 1024;
  localparam int BIN_W            = 10;
  localparam int FREQ_W           = 32;
  localparam int RAND_W           = 16;
  localparam int RANGE_W          = 14;
  localparam int VAL_W            = 32;
  localparam int IN_TDATA_W       = 112;
  localparam int OUT_TDATA_W      = 48;

  localparam logic [RANGE_W-1:0] PITCH_RANGE_RESET = 14'd100;

  // One stored bin entry: started flag; offset, target and step, all Q17.15.
  typedef struct packed {
    logic                    started;
    logic signed [VAL_W-1:0] offset;
    logic signed [VAL_W-1:0] target;
    logic signed [VAL_W-1:0] step;
  } bin_state_t;

  localparam int STATE_W = $bits(bin_state_t);

  // Saturate a 33-bit sum to the signed 32-bit range.
  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [VAL_W:0] x);
    logic signed [VAL_W-1:0] r;
    begin
      if (x[VAL_W] != x[VAL_W-1]) begin
        r = x[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
      end else begin
        r = x[VAL_W-1:0];
      end
      return r;
    end
  endfunction

endpackage

/* design/sbrpd_bin_mem.sv */
// Per-bin state memory: one synchronous array of bin_state_t with a registered read.
// Runs a clearing pass after reset. Depends on sbrpd_pkg.
`timescale 1ns / 1ps

module sbrpd_bin_mem
  import sbrpd_pkg::*;
#(
  parameter int NUM_BINS = NUM_BINS_DEFAULT,
  parameter int AW       = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output bin_state_t    rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  bin_state_t    wr_data,
  output logic          clr_busy
);

  bin_state_t mem [NUM_BINS];

  logic          clr_active;
  logic [AW-1:0] clr_addr;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  bin_state_t    mem_wdata;

  assign clr_busy = clr_active;

  // The clearing pass only needs to drop the started flag of every entry.
  always_comb begin
    if (clr_active) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else begin
      mem_we    = wr_en;
      mem_waddr = wr_addr;
      mem_wdata = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      if (clr_addr == AW'(NUM_BINS - 1)) begin
        clr_active <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/sbrpd_draw.sv */
// Scales the four Q1.15 random inputs by the pitch range into Q17.15 targets and steps.
// Pure logic, registered by the caller. Depends on sbrpd_pkg.
`timescale 1ns / 1ps

module sbrpd_draw
  import sbrpd_pkg::*;
(
  input  logic signed [RAND_W-1:0] rand_target,
  input  logic signed [RAND_W-1:0] rand_step,
  input  logic signed [RAND_W-1:0] rand_init_target,
  input  logic signed [RAND_W-1:0] rand_init_step,
  input  logic [RANGE_W-1:0]       pitch_range,
  output logic signed [VAL_W-1:0]  new_target,
  output logic signed [VAL_W-1:0]  new_step,
  output logic signed [VAL_W-1:0]  init_target,
  output logic signed [VAL_W-1:0]  init_step
);

  localparam int PROD_W = RAND_W + RANGE_W + 1;

  logic signed [RANGE_W:0]   range_s;
  logic signed [PROD_W-1:0]  p_tgt, p_stp, p_itgt, p_istp;

  assign range_s = $signed({1'b0, pitch_range});

  assign p_tgt  = rand_target      * range_s;
  assign p_stp  = rand_step        * range_s;
  assign p_itgt = rand_init_target * range_s;
  assign p_istp = rand_init_step   * range_s;

  // Target is the product itself; step is the product divided by 16, rounded down.
  assign new_target  = VAL_W'(p_tgt);
  assign init_target = VAL_W'(p_itgt);
  assign new_step    = VAL_W'(p_stp >>> 4);
  assign init_step   = VAL_W'(p_istp >>> 4);

endmodule

/* design/sbrpd_update.sv */
// Read-modify step for one bin: output frequency, offset advance and target re-draw.
// Combinational; the top level registers around it. Depends on sbrpd_pkg.
`timescale 1ns / 1ps

module sbrpd_update
  import sbrpd_pkg::*;
(
  input  bin_state_t              cur,
  input  logic signed [FREQ_W-1:0] freq_in,
  input  logic signed [VAL_W-1:0]  new_target,
  input  logic signed [VAL_W-1:0]  new_step,
  input  logic signed [VAL_W-1:0]  init_target,
  input  logic signed [VAL_W-1:0]  init_step,
  output logic signed [FREQ_W-1:0] freq_out,
  output bin_state_t              nxt
);

  logic signed [VAL_W-1:0] off, tgt, stp, val;
  logic                    falling, redraw, flip;

  always_comb begin
    // A bin seen for the first time starts from offset zero and its initial draw.
    if (cur.started) begin
      off = cur.offset;
      tgt = cur.target;
      stp = cur.step;
    end else begin
      off = '0;
      tgt = init_target;
      stp = init_step;
    end

    freq_out = sat32(33'(freq_in) + 33'(off));
    val      = sat32(33'(off) + 33'(stp));

    falling = stp[VAL_W-1];
    redraw  = falling ? (val < tgt) : (val > tgt);
    flip    = falling ? (val > new_target) : (val < new_target);

    nxt.started = 1'b1;
    nxt.offset  = val;
    if (redraw) begin
      nxt.target = new_target;
      nxt.step   = flip ? -new_step : new_step;
    end else begin
      nxt.target = tgt;
      nxt.step   = stp;
    end
  end

endmodule

/* design/spectral_bin_random_pitch_drift_top.sv */
// Top level of the per-bin random pitch drift block: stream ports, pipeline and forwarding.
// Instantiates sbrpd_draw, sbrpd_bin_mem and sbrpd_update; depends on sbrpd_pkg.
//
//  Channel   | Direction | Handshake                    | Contents
//  ----------+-----------+------------------------------+-------------------------------
//  s_axis    | in        | s_axis_tvalid/s_axis_tready  | bin index, frequency, 4 randoms
//  m_axis    | out       | m_axis_tvalid/m_axis_tready  | bin index, shifted frequency
//  cfg       | in        | cfg_we                       | pitch_range
//
// One transaction per clock sustained while m_axis is not stalled; a result passes from the
// input through the stage 1 register into the output register that drives m_axis.
// The rate is set by the read-modify-write of the bin state memory, which has one read and
// one write port; a bin that repeats on consecutive transactions is served by forwarding
// the just-written entry.
// After reset a clearing pass over all NUM_BINS entries runs with s_axis_tready low.
// A stalled output holds the pipeline; the input side keeps taking transactions while the
// output register can still be refilled in the same cycle.
`timescale 1ns / 1ps

module spectral_bin_random_pitch_drift_top
  import sbrpd_pkg::*;
#(
  parameter int NUM_BINS = NUM_BINS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // bin_index[9:0], freq_in[41:10], rand_target[57:42], rand_step[73:58],
  // rand_init_target[89:74], rand_init_step[105:90], zero fill[111:106]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // out_bin_index[9:0], freq_out[41:10], zero fill[47:42]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_we,
  input  logic [RANGE_W-1:0]     cfg_wdata
);

  localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int EW = AW + BIN_W;

  // Input field unpacking.
  logic [BIN_W-1:0]         in_idx;
  logic signed [FREQ_W-1:0] in_freq;
  logic signed [RAND_W-1:0] in_rt, in_rs, in_rit, in_ris;

  assign in_idx  = s_axis_tdata[9:0];
  assign in_freq = s_axis_tdata[41:10];
  assign in_rt   = s_axis_tdata[57:42];
  assign in_rs   = s_axis_tdata[73:58];
  assign in_rit  = s_axis_tdata[89:74];
  assign in_ris  = s_axis_tdata[105:90];

  logic [RANGE_W-1:0] pitch_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      pitch_range <= PITCH_RANGE_RESET;
    end else if (cfg_we) begin
      pitch_range <= cfg_wdata;
    end
  end

  logic [EW-1:0] idx_ext;
  logic [AW-1:0] in_addr;
  logic          in_range;

  assign idx_ext  = EW'(in_idx);
  assign in_addr  = idx_ext[AW-1:0];
  assign in_range = (32'(in_idx) < NUM_BINS);

  logic signed [VAL_W-1:0] d_tgt, d_stp, d_itgt, d_istp;

  sbrpd_draw u_draw (
    .rand_target      (in_rt),
    .rand_step        (in_rs),
    .rand_init_target (in_rit),
    .rand_init_step   (in_ris),
    .pitch_range      (pitch_range),
    .new_target       (d_tgt),
    .new_step         (d_stp),
    .init_target      (d_itgt),
    .init_step        (d_istp)
  );

  // Stage 1: memory read in flight, scaled randoms registered.
  logic                     s1_valid;
  logic [BIN_W-1:0]         s1_idx;
  logic [AW-1:0]            s1_addr;
  logic                     s1_in_range;
  logic signed [FREQ_W-1:0] s1_freq;
  logic signed [VAL_W-1:0]  s1_tgt, s1_stp, s1_itgt, s1_istp;
  logic                     s1_fwd_hit;
  bin_state_t               fwd_data;

  logic       clr_busy;
  logic       in_accept;
  logic       s1_adv;
  logic       wr_en;
  bin_state_t rd_data;
  bin_state_t cur_state;
  bin_state_t nxt_state;
  logic signed [FREQ_W-1:0] upd_freq;
  logic signed [FREQ_W-1:0] res_freq;

  assign s1_adv        = s1_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !clr_busy && (!s1_valid || s1_adv);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign wr_en         = s1_adv && s1_in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_idx      <= in_idx;
      s1_addr     <= in_addr;
      s1_in_range <= in_range;
      s1_freq     <= in_freq;
      s1_tgt      <= d_tgt;
      s1_stp      <= d_stp;
      s1_itgt     <= d_itgt;
      s1_istp     <= d_istp;
      // The memory read at this edge misses the write of the same edge; forward it.
      s1_fwd_hit  <= wr_en && in_range && (s1_addr == in_addr);
    end
    if (wr_en) begin
      fwd_data <= nxt_state;
    end
  end

  sbrpd_bin_mem #(
    .NUM_BINS (NUM_BINS),
    .AW       (AW)
  ) u_mem (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (in_accept),
    .rd_addr  (in_addr),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (s1_addr),
    .wr_data  (nxt_state),
    .clr_busy (clr_busy)
  );

  assign cur_state = s1_fwd_hit ? fwd_data : rd_data;

  sbrpd_update u_update (
    .cur         (cur_state),
    .freq_in     (s1_freq),
    .new_target  (s1_tgt),
    .new_step    (s1_stp),
    .init_target (s1_itgt),
    .init_step   (s1_istp),
    .freq_out    (upd_freq),
    .nxt         (nxt_state)
  );

  assign res_freq = s1_in_range ? upd_freq : s1_freq;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_adv) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      m_axis_tdata <= {6'd0, res_freq, s1_idx};
    end
  end

endmodule

/* tb/tb_spectral_bin_random_pitch_drift_top.sv */
// Self-checking testbench for spectral_bin_random_pitch_drift_top: directed and random bins
// are streamed in, and each result is compared against an in-bench per-bin drift predictor.
// Depends on sbrpd_pkg and the design folder; needs no files or arguments.
`timescale 1ns / 1ps

module tb_spectral_bin_random_pitch_drift_top;
  import sbrpd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    bit [BIN_W-1:0]         bin;
    bit signed [FREQ_W-1:0] freq;
    bit signed [RAND_W-1:0] rt;
    bit signed [RAND_W-1:0] rs;
    bit signed [RAND_W-1:0] rit;
    bit signed [RAND_W-1:0] ris;
  } drift_item_t;

  typedef struct {
    bit [BIN_W-1:0]         bin;
    bit signed [FREQ_W-1:0] freq;
  } drift_out_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we = 1'b0;
  logic [RANGE_W-1:0]     cfg_wdata = '0;

  // Predictor state: one entry per bin plus the current pitch range.
  logic [RANGE_W-1:0] pitch_range = PITCH_RANGE_RESET;
  int                 drift_offset [NUM_BINS_DEFAULT];
  int                 drift_target [NUM_BINS_DEFAULT];
  int                 drift_step   [NUM_BINS_DEFAULT];
  bit                 bin_live     [NUM_BINS_DEFAULT];

  drift_item_t pending_items[$];
  drift_out_t  expected_out[$];
  drift_item_t cur_item;
  bit          took = 1'b0;
  int          items_total = 0;
  int          results_seen = 0;
  int          error_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 9;
  int          recv_idle_pct = 81;
  bit [BIN_W-1:0] last_bin = '0;

  spectral_bin_random_pitch_drift_top uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int clip32(input longint x);
    if (x > longint'(32'sh7fffffff)) return 32'sh7fffffff;
    if (x < -longint'(32'sh7fffffff) - 1) return 32'sh80000000;
    return int'(x);
  endfunction

  function automatic int scaled_target(input bit signed [RAND_W-1:0] r);
    longint p;
    p = longint'(r) * longint'(pitch_range);
    return int'(p);
  endfunction

  // Divide by 16, rounding toward minus infinity.
  function automatic int scaled_step(input bit signed [RAND_W-1:0] r);
    longint p;
    p = longint'(r) * longint'(pitch_range);
    return int'(p >>> 4);
  endfunction

  task automatic advance_bin(input drift_item_t it);
    drift_out_t o;
    longint     off;
    longint     stp;
    longint     moved;
    bit         falling;
    o.bin = it.bin;
    if (!bin_live[it.bin]) begin
      drift_offset[it.bin] = 0;
      drift_target[it.bin] = scaled_target(it.rit);
      drift_step[it.bin]   = scaled_step(it.ris);
      bin_live[it.bin]     = 1'b1;
    end
    off = drift_offset[it.bin];
    stp = drift_step[it.bin];
    falling = (stp < 0);
    o.freq = clip32(longint'(it.freq) + off);
    moved = clip32(off + stp);
    drift_offset[it.bin] = int'(moved);
    // Once the offset has passed its target, a new target and step are drawn, and the
    // step turns around if the offset already lies beyond the new target.
    if (falling ? (moved < drift_target[it.bin]) : (moved > drift_target[it.bin])) begin
      drift_target[it.bin] = scaled_target(it.rt);
      drift_step[it.bin]   = scaled_step(it.rs);
      if (falling ? (moved > drift_target[it.bin]) : (moved < drift_target[it.bin]))
        drift_step[it.bin] = -drift_step[it.bin];
    end
    expected_out.push_back(o);
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    error_count++;
  endtask

  function automatic drift_item_t make_item(input int b, input int f, input int rt,
                                            input int rs, input int rit, input int ris);
    drift_item_t it;
    it.bin  = b[BIN_W-1:0];
    it.freq = f;
    it.rt   = rt[RAND_W-1:0];
    it.rs   = rs[RAND_W-1:0];
    it.rit  = rit[RAND_W-1:0];
    it.ris  = ris[RAND_W-1:0];
    return it;
  endfunction

  function automatic drift_item_t random_item();
    drift_item_t it;
    int          pick;
    pick = $urandom_range(99);
    // Mostly a small pool of bins so that their drift runs through many re-draws.
    if (pick < 15) it.bin = last_bin;
    else if (pick < 85) it.bin = BIN_W'($urandom_range(15));
    else it.bin = BIN_W'($urandom);
    last_bin = it.bin;
    pick = $urandom_range(99);
    if (pick < 8) it.freq = 32'sh7fffffff;
    else if (pick < 16) it.freq = 32'sh80000000;
    else it.freq = $urandom;
    it.rt = RAND_W'($urandom);
    if ($urandom_range(99) < 30) it.rs = RAND_W'(int'($urandom_range(64)) - 32);
    else it.rs = RAND_W'($urandom);
    it.rit = RAND_W'($urandom);
    it.ris = RAND_W'($urandom);
    return it;
  endfunction

  task automatic add_item(input drift_item_t it);
    pending_items.push_back(it);
    items_total++;
  endtask

  task automatic run_segment(input int send_pct, input int recv_pct, input bit write_cfg,
                             input logic [RANGE_W-1:0] range, input int n_items);
    int k;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    if (write_cfg) begin
      @(negedge clk);
      cfg_wdata <= range;
      cfg_we <= 1'b1;
      pitch_range = range;
      @(negedge clk);
      cfg_we <= 1'b0;
    end
    for (k = 0; k < n_items; k++) add_item(random_item());
    while (results_seen != items_total) @(posedge clk);
  endtask

  // Driver: a new transaction is presented only once the previous one was taken.
  always @(negedge clk) begin
    if (!s_axis_tvalid || took) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_item = pending_items.pop_front();
        s_axis_tdata <= {6'b0, cur_item.ris, cur_item.rit, cur_item.rs, cur_item.rt,
                         cur_item.freq, cur_item.bin};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    took = !rst && s_axis_tvalid && s_axis_tready;
    if (took) advance_bin(cur_item);
  end

  // Monitor: every output transaction is checked against the oldest prediction.
  always @(posedge clk) begin
    drift_out_t exp_o;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (expected_out.size() == 0) begin
        report_mismatch($sformatf("unexpected result bin=%0d freq=%0d",
                                  m_axis_tdata[9:0], $signed(m_axis_tdata[41:10])));
      end else begin
        exp_o = expected_out.pop_front();
        if (m_axis_tdata[9:0] !== exp_o.bin)
          report_mismatch($sformatf("out_bin_index got %0d want %0d",
                                    m_axis_tdata[9:0], exp_o.bin));
        if (m_axis_tdata[41:10] !== exp_o.freq)
          report_mismatch($sformatf("freq_out bin %0d got %0d want %0d", exp_o.bin,
                                    $signed(m_axis_tdata[41:10]), exp_o.freq));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset pitch range.
    add_item(make_item(0, 0, 0, 0, 0, 0));                       // zero step, zero target
    add_item(make_item(0, 32'sh7fffffff, 0, 0, 0, 0));           // same bin back to back
    add_item(make_item(1023, 32'sh80000000, 32767, 32767, -32768, -32768));
    add_item(make_item(1023, 32'sh80000000, 32767, 32767, -32768, -32768));  // low clamp
    add_item(make_item(1, 32'sh7fffffff, 0, 0, 32767, 32767));
    add_item(make_item(1, 32'sh7fffffff, 0, 0, 32767, 32767));   // high clamp
    add_item(make_item(2, 1, -32768, -32768, 1, 32767));         // re-draw on first visit
    add_item(make_item(2, 2, 32767, 32767, 0, 0));
    add_item(make_item(3, 3, -1, 1, -1, 32767));
    add_item(make_item(4, 4, 32767, 16, 0, 32767));              // rising step turns around
    add_item(make_item(4, 5, 0, 0, 0, 0));
    add_item(make_item(4, 6, 0, 0, 0, 0));
    add_item(make_item(5, 7, -32768, 16, 0, -32768));            // falling step turns around
    add_item(make_item(5, 8, 0, 0, 0, 0));
    add_item(make_item(6, -1, -1, -1, -1, -1));
    add_item(make_item(7, 9, 0, 0, 0, -1));                      // negative step rounds down
    add_item(make_item(10'h2aa, 32'sh55555555, 16'h5555, 16'h5555, 16'h5555, 16'h5555));
    add_item(make_item(10'h155, 32'shaaaaaaaa, 16'haaaa, 16'haaaa, 16'haaaa, 16'haaaa));
    run_segment(9, 81, 1'b0, '0, 0);

    run_segment(9, 81, 1'b1, 14'd16383, 90);
    run_segment(9, 81, 1'b1, 14'd0, 90);
    run_segment(81, 9, 1'b1, RANGE_W'($urandom_range(16383)), 90);
    run_segment(81, 9, 1'b1, 14'd1, 90);
    run_segment(0, 0, 1'b1, 14'd16383, 95);
    run_segment(0, 0, 1'b1, RANGE_W'($urandom_range(16383)), 95);

    repeat (4) @(posedge clk);
    if (expected_out.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_out.size()));
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
